@@ rtl/core/mcas_pkg.sv @@
// ----------------------------------------------------------------------------
// mcas_pkg
// Shared types and constants for the min-cost assignment solver.
// ----------------------------------------------------------------------------
package mcas_pkg;

    // Fixed field widths of the port words
    localparam int SIZE_W  = 5;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 4;
    localparam int TOTAL_W = 24;

    // Width of potentials, slacks and the running total
    localparam int VAL_W = 48;

    localparam logic signed [VAL_W-1:0] SLACK_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] TOTAL_HI  = VAL_W'(64'sd8388607);
    localparam logic signed [VAL_W-1:0] TOTAL_LO  = VAL_W'(-64'sd8388608);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_ROW,
        S_STEP,
        S_SCAN_RD,
        S_SCAN_EV,
        S_UPD,
        S_AUG,
        S_TOT_RD,
        S_TOT_EV,
        S_OUT
    } t_state;

endpackage

@@ rtl/core/min_cost_assignment_solver.sv @@
// Flow: n*n input words load at one word a cycle; the last one starts a solve
// that runs up to (n+1) search passes for each of n rows, then totals the
// answer and sends n result words at one a cycle while i_ready is high.
// Throughput: one matrix at a time; columns are scanned one by one on the
// shared adder/comparator, with the cost memory's single read port setting pace.
// Reset: synchronous, active low; size returns to 16 (clamped) and loading restarts.
// ----------------------------------------------------------------------------
// min_cost_assignment_solver
// Hungarian method with row and column potentials on a small sequencer.
// ----------------------------------------------------------------------------
module min_cost_assignment_solver #(
    parameter int MAX_SIZE   = 16,
    parameter int COST_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration: matrix size
    input  logic                               i_cfg_wr_en,
    input  logic [mcas_pkg::SIZE_W-1:0]        i_cfg_wr_data,
    // input words: cost entries, row-major
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [COST_WIDTH-1:0]       i_cost,
    // result words: one per column
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [mcas_pkg::ROW_W-1:0]         o_row,
    output logic [mcas_pkg::COL_W-1:0]         o_column,
    output logic signed [mcas_pkg::TOTAL_W-1:0] o_total_cost,
    output logic                               o_last_pair
);
    import mcas_pkg::*;

    // Index width leaves the all-ones code free as the "none" marker
    localparam int IW    = $clog2(MAX_SIZE + 2);
    localparam int DEPTH = MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int CW    = (SIZE_W > IW ? SIZE_W : IW) + 1;
    localparam logic [IW-1:0] NONE_MARK = {IW{1'b1}};

    // Clamp a written size into 1..MAX_SIZE
    function automatic logic [IW-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [CW-1:0] w;
        w = CW'(v);
        if (w == '0)                  return IW'(1);
        else if (w > CW'(MAX_SIZE))   return IW'(MAX_SIZE);
        else                          return IW'(w);
    endfunction

    t_state r_state, n_state;

    // Cost store
    logic [COST_WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [COST_WIDTH-1:0] r_rd;
    logic [AW-1:0]         rd_addr;

    logic [IW-1:0]          r_n;
    logic [LW-1:0]          r_total_entries;
    logic [LW-1:0]          r_load_count;

    logic signed [VAL_W-1:0] r_row_pot [0:MAX_SIZE];
    logic signed [VAL_W-1:0] r_col_pot [0:MAX_SIZE];
    logic signed [VAL_W-1:0] r_slack   [0:MAX_SIZE];
    logic [IW-1:0]           r_match   [0:MAX_SIZE];
    logic [IW-1:0]           r_path    [0:MAX_SIZE];
    logic [MAX_SIZE:0]       r_used;

    logic [IW-1:0]           r_i, r_j, r_j0, r_v, r_guard;
    logic                    r_vfound;
    logic [AW-1:0]           r_base;
    logic signed [VAL_W-1:0] r_upot, r_delta, r_acc;
    logic signed [TOTAL_W-1:0] r_total;

    logic                    in_acc, out_acc, load_last;
    logic [IW-1:0]           cur, sel_row, upd_row, j1, tot_r;
    logic signed [VAL_W-1:0] cost_ext, slack_r, slack_new, sum_next;
    logic                    tot_ok;

    assign in_acc    = i_valid && o_ready;
    assign out_acc   = o_valid && i_ready;
    assign load_last = (r_load_count + LW'(1)) == r_total_entries;

    // Row whose costs the current search pass scans; unknown rows fall to row 1
    always_comb begin
        sel_row = (r_match[r_j0] > r_n) ? '0 : r_match[r_j0];
        cur     = (sel_row == '0) ? IW'(1) : sel_row;
    end

    assign upd_row = (r_match[r_j] > r_n) ? '0 : r_match[r_j];
    assign j1      = (r_path[r_j0] > r_n) ? '0 : r_path[r_j0];
    assign tot_r   = r_match[r_j];
    assign tot_ok  = (tot_r >= IW'(1)) && (tot_r <= r_n);

    assign cost_ext  = {{(VAL_W-COST_WIDTH){r_rd[COST_WIDTH-1]}}, r_rd};
    assign slack_r   = cost_ext + r_upot + r_col_pot[r_j];
    assign slack_new = (slack_r < r_slack[r_j]) ? slack_r : r_slack[r_j];
    assign sum_next  = r_acc + (tot_ok ? cost_ext : '0);

    // Read address: scan walks the current row, total follows the matches
    always_comb begin
        if (r_state == S_TOT_RD) begin
            rd_addr = AW'(tot_r - IW'(1)) * AW'(r_n) + AW'(r_j - IW'(1));
        end else begin
            rd_addr = r_base + AW'(r_j - IW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mem[r_load_count[AW-1:0]] <= i_cost;
        end
        r_rd <= r_mem[rd_addr];
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (in_acc && load_last) n_state = S_INIT;
            S_INIT:    n_state = S_ROW;
            S_ROW:     n_state = S_STEP;
            S_STEP:    n_state = S_SCAN_RD;
            S_SCAN_RD: n_state = S_SCAN_EV;
            S_SCAN_EV: begin
                if (r_j == r_n) begin
                    if (r_vfound || (!r_used[r_j] && slack_new < r_delta)) begin
                        n_state = S_UPD;
                    end else begin
                        n_state = S_AUG;
                    end
                end else begin
                    n_state = S_SCAN_RD;
                end
            end
            S_UPD: begin
                if (r_j == r_n) begin
                    if (r_match[r_v] == NONE_MARK || r_guard == r_n) n_state = S_AUG;
                    else                                            n_state = S_STEP;
                end
            end
            S_AUG: begin
                if (r_j0 == '0 || r_guard > r_n) begin
                    n_state = (r_i == r_n) ? S_TOT_RD : S_ROW;
                end
            end
            S_TOT_RD:  n_state = S_TOT_EV;
            S_TOT_EV:  n_state = (r_j == r_n) ? S_OUT : S_TOT_RD;
            S_OUT:     if (out_acc && r_j == r_n) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Size and load counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n             <= clamp_size(SIZE_W'(16));
            r_total_entries <= LW'(clamp_size(SIZE_W'(16))) * LW'(clamp_size(SIZE_W'(16)));
            r_load_count    <= '0;
        end else if (i_cfg_wr_en) begin
            r_n             <= clamp_size(i_cfg_wr_data);
            r_total_entries <= LW'(clamp_size(i_cfg_wr_data)) * LW'(clamp_size(i_cfg_wr_data));
            r_load_count    <= '0;
        end else if (in_acc) begin
            r_load_count    <= load_last ? '0 : r_load_count + LW'(1);
        end
    end

    // Solver datapath: one column per step on the shared adder and comparator
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_INIT: begin
                for (int k = 0; k <= MAX_SIZE; k++) begin
                    r_row_pot[k] <= '0;
                    r_col_pot[k] <= '0;
                    r_match[k]   <= NONE_MARK;
                    r_path[k]    <= NONE_MARK;
                end
                r_i <= IW'(1);
            end
            S_ROW: begin
                r_match[0] <= r_i;
                for (int k = 0; k <= MAX_SIZE; k++) begin
                    r_slack[k] <= SLACK_MAX;
                end
                r_used  <= '0;
                r_j0    <= '0;
                r_guard <= '0;
            end
            S_STEP: begin
                // mark the current column, latch its row potential and row base
                r_used[r_j0] <= 1'b1;
                r_upot       <= r_row_pot[cur];
                r_base       <= AW'(cur - IW'(1)) * AW'(r_n);
                r_j          <= IW'(1);
                r_delta      <= SLACK_MAX;
                r_vfound     <= 1'b0;
            end
            S_SCAN_EV: begin
                if (!r_used[r_j]) begin
                    if (slack_r < r_slack[r_j]) begin
                        r_slack[r_j] <= slack_r;
                        r_path[r_j]  <= r_j0;
                    end
                    if (slack_new < r_delta) begin
                        r_delta  <= slack_new;
                        r_v      <= r_j;
                        r_vfound <= 1'b1;
                    end
                end
                if (r_j == r_n) begin
                    r_j     <= '0;
                    r_guard <= (n_state == S_AUG) ? '0 : r_guard;
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            S_UPD: begin
                if (r_used[r_j]) begin
                    r_row_pot[upd_row] <= r_row_pot[upd_row] - r_delta;
                    r_col_pot[r_j]     <= r_col_pot[r_j] + r_delta;
                end else begin
                    r_slack[r_j] <= r_slack[r_j] - r_delta;
                end
                r_j <= r_j + IW'(1);
                if (r_j == r_n) begin
                    r_j0    <= r_v;
                    r_guard <= (n_state == S_AUG) ? '0 : r_guard + IW'(1);
                end
            end
            S_AUG: begin
                if (r_j0 == '0 || r_guard > r_n) begin
                    r_i   <= r_i + IW'(1);
                    r_j   <= IW'(1);
                    r_acc <= '0;
                end else begin
                    // walk back along the alternating path
                    r_match[r_j0] <= r_match[j1];
                    r_j0          <= j1;
                    r_guard       <= r_guard + IW'(1);
                end
            end
            S_TOT_EV: begin
                r_acc <= sum_next;
                if (r_j == r_n) begin
                    if (sum_next > TOTAL_HI)      r_total <= TOTAL_HI[TOTAL_W-1:0];
                    else if (sum_next < TOTAL_LO) r_total <= TOTAL_LO[TOTAL_W-1:0];
                    else                          r_total <= sum_next[TOTAL_W-1:0];
                    r_j <= IW'(1);
                end else begin
                    r_j <= r_j + IW'(1);
                end
            end
            S_OUT: begin
                if (out_acc) r_j <= r_j + IW'(1);
            end
            default: begin
            end
        endcase
    end

    // Result words straight from held state; stable while waiting
    logic [IW+ROW_W-1:0] row_ext;
    logic [IW+COL_W-1:0] col_ext;

    assign row_ext = {{ROW_W{1'b0}}, (tot_ok ? tot_r - IW'(1) : '0)};
    assign col_ext = {{COL_W{1'b0}}, r_j - IW'(1)};

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = (r_state == S_OUT);
    assign o_row        = row_ext[ROW_W-1:0];
    assign o_column     = col_ext[COL_W-1:0];
    assign o_total_cost = r_total;
    assign o_last_pair  = o_valid && (r_j == r_n);

endmodule

@@ rtl/core/mcas_checker.sv @@
// ----------------------------------------------------------------------------
// mcas_checker
// Port-level checks on the assignment solver, bound to the top level.
// ----------------------------------------------------------------------------
module mcas_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_ready,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [mcas_pkg::COL_W-1:0]         o_column,
    input logic signed [mcas_pkg::TOTAL_W-1:0] o_total_cost,
    input logic                               o_last_pair
);
    // results and new words never overlap
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while results pending");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_pair |-> o_valid) else $error("last marker without valid");

    a_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last_pair) |=> o_ready)
        else $error("not ready after final pair");

    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_pair) |=> (o_valid && $stable(o_total_cost)))
        else $error("total changed within one answer");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_column)))
        else $error("stalled word changed");

endmodule

bind min_cost_assignment_solver mcas_checker u_mcas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_ready      (o_ready),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_column     (o_column),
    .o_total_cost (o_total_cost),
    .o_last_pair  (o_last_pair)
);
